FILE: hw/rtl/hlxfp_pkg.sv
// ----------------------------------------------------------------------------
// hlxfp_pkg
// Shared types and constants for the header / length / xor frame parser.
// ----------------------------------------------------------------------------
package hlxfp_pkg;

	// default sizing
	localparam int BUF_SIZE_DEF   = 64;
	localparam int HEADER_MAX_DEF = 4;

	// parser phase
	typedef enum logic [1:0] {
		PH_HUNT = 2'd0,
		PH_LEN  = 2'd1,
		PH_BODY = 2'd2
	} phase_t;

	// frame status codes
	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_XOR_BAD  = 2'd1,
		ST_OVERSIZE = 2'd2
	} status_t;

	// register indexes on the config port
	localparam logic REG_HDR_PATTERN = 1'b0;
	localparam logic REG_HDR_LENGTH  = 1'b1;

	// reset values of the config registers
	localparam logic [31:0] HDR_PATTERN_RST = 32'h0000_0000;
	localparam logic [2:0]  HDR_LENGTH_RST  = 3'd1;

endpackage

FILE: hw/rtl/header_length_xor_frame_parser.sv
// ----------------------------------------------------------------------------
// header_length_xor_frame_parser
// Serial frame parser: header hunt, length byte, xor checksum check.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries received bytes, one per request (s_tdata = rx_byte).
//   The parser hunts for a header of header_length bytes taken from
//   header_pattern, then takes a length byte L and L further bytes, the
//   last being the xor of the length byte and the bytes between.
//   m_* carries one request per frame end: m_tdata = {frequency, command},
//   m_tuser = status (ok, checksum mismatch, length at or above buffer size).
//   Latency: the result is valid on the cycle after the byte that ends the
//   frame is accepted. Throughput: one byte per cycle while the single
//   result register is free or draining; each byte passes through the
//   header compares or the xor, and a counter update.
//   Reset clears the parser to header hunting and the registers to pattern
//   zero and length one. When the receiver stalls with a result pending,
//   s_tready follows m_tready, so a byte is only taken if the result
//   register drains in the same cycle.
//   Config writes use the APB-style port; the user must write only while idle (not enforced).
// ----------------------------------------------------------------------------
module header_length_xor_frame_parser
	import hlxfp_pkg::*;
#(
	parameter int BUF_SIZE   = BUF_SIZE_DEF,
	parameter int HEADER_MAX = HEADER_MAX_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// config port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// byte input
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] rx_byte
	// frame result
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // [7:0] command, [39:8] frequency
	output logic [1:0]  m_tuser    // [1:0] status
);

	localparam int CNT_W = (HEADER_MAX > 1) ? $clog2(HEADER_MAX) : 1;

	// header byte k of the pattern, zero beyond the 32-bit register
	function automatic logic [7:0] hdr_byte(input logic [31:0] pat,
		input logic [CNT_W-1:0] k);
		logic [7:0] r;
		r = 8'd0;
		if (32'(k) < 32'd4) begin
			r = pat[8*k +: 8];
		end
		return r;
	endfunction

	// config registers
	logic [31:0] hdr_pattern_q;
	logic [2:0]  hdr_length_q;

	// parser state
	phase_t           phase_q, phase_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;
	logic [7:0]       frame_len_q, frame_len_d;
	logic [7:0]       idx_q, idx_d;
	logic [7:0]       xor_q, xor_d;
	logic [7:0]       cmd_q, cmd_d;
	logic [31:0]      freq_q, freq_d;

	// result register
	logic        m_tvalid_q;
	logic [39:0] m_tdata_q;
	logic [1:0]  m_tuser_q;

	// combinational results
	logic        in_acc;
	logic        emit;
	status_t     res_status;
	logic [3:0]  len_eff;
	logic [CNT_W-1:0] cnt_cur;
	logic [3:0]  cnt_new;
	logic        hunt_done;
	logic        len_over;
	logic        len_zero;
	logic        body_end;
	logic [7:0]  b;

	assign b        = s_tdata;
	assign s_tready = !m_tvalid_q || m_tready;
	assign in_acc   = s_tvalid && s_tready;

	// config write and read
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hdr_pattern_q <= HDR_PATTERN_RST;
			hdr_length_q  <= HDR_LENGTH_RST;
		end else if (psel && penable && pwrite && pready) begin
			unique case (paddr[2])
				REG_HDR_PATTERN: hdr_pattern_q <= pwdata;
				REG_HDR_LENGTH:  hdr_length_q  <= pwdata[2:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_HDR_PATTERN: prdata = hdr_pattern_q;
			REG_HDR_LENGTH:  prdata = {29'd0, hdr_length_q};
			default:         prdata = 32'd0;
		endcase
	end

	// effective header length, clamped to 1..HEADER_MAX
	always_comb begin
		if (hdr_length_q == 3'd0) begin
			len_eff = 4'd1;
		end else if (4'(hdr_length_q) > 4'(HEADER_MAX)) begin
			len_eff = 4'(HEADER_MAX);
		end else begin
			len_eff = 4'(hdr_length_q);
		end
	end

	// header match step, a mismatch retries the byte as header byte 0
	always_comb begin
		cnt_cur = (4'(cnt_q) >= len_eff) ? '0 : cnt_q;
		if (b == hdr_byte(hdr_pattern_q, cnt_cur)) begin
			cnt_new = 4'(cnt_cur) + 4'd1;
		end else if (b == hdr_byte(hdr_pattern_q, '0)) begin
			cnt_new = 4'd1;
		end else begin
			cnt_new = 4'd0;
		end
		hunt_done = (cnt_new >= len_eff);
	end

	// frame condition flags
	assign len_over = ({1'b0, b} >= 9'(BUF_SIZE));
	assign len_zero = (b == 8'd0);
	assign body_end = (idx_q >= frame_len_q);

	// next phase
	always_comb begin
		unique case (phase_q)
			PH_LEN: begin
				phase_d = (len_over || len_zero) ? PH_HUNT : PH_BODY;
			end
			PH_BODY: begin
				phase_d = body_end ? PH_HUNT : PH_BODY;
			end
			default: begin
				phase_d = hunt_done ? PH_LEN : PH_HUNT;
			end
		endcase
	end

	// datapath and result
	always_comb begin
		cnt_d       = cnt_q;
		frame_len_d = frame_len_q;
		idx_d       = idx_q;
		xor_d       = xor_q;
		cmd_d       = cmd_q;
		freq_d      = freq_q;
		emit        = 1'b0;
		res_status  = ST_OK;
		unique case (phase_q)
			PH_LEN: begin
				frame_len_d = b;
				xor_d       = b;
				idx_d       = 8'd1;
				cmd_d       = 8'd0;
				freq_d      = 32'd0;
				cnt_d       = '0;
				if (len_over) begin
					emit       = 1'b1;
					res_status = ST_OVERSIZE;
				end else if (len_zero) begin
					emit       = 1'b1;
					res_status = ST_OK;
				end
			end
			PH_BODY: begin
				unique case (idx_q)
					8'd1:    cmd_d  = b;
					8'd2:    freq_d = freq_q | {b, 24'd0};
					8'd3:    freq_d = freq_q | {8'd0, b, 16'd0};
					8'd4:    freq_d = freq_q | {16'd0, b, 8'd0};
					8'd5:    freq_d = freq_q | {24'd0, b};
					default: ;
				endcase
				if (body_end) begin
					emit       = 1'b1;
					res_status = (b == xor_q) ? ST_OK : ST_XOR_BAD;
					cnt_d      = '0;
				end else begin
					xor_d = xor_q ^ b;
					idx_d = idx_q + 8'd1;
				end
			end
			default: begin
				cnt_d = hunt_done ? '0 : CNT_W'(cnt_new);
			end
		endcase
	end

	// parser state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_HUNT;
			cnt_q       <= '0;
			frame_len_q <= 8'd0;
			idx_q       <= 8'd0;
			xor_q       <= 8'd0;
			cmd_q       <= 8'd0;
			freq_q      <= 32'd0;
		end else if (in_acc) begin
			phase_q     <= phase_d;
			cnt_q       <= cnt_d;
			frame_len_q <= frame_len_d;
			idx_q       <= idx_d;
			xor_q       <= xor_d;
			cmd_q       <= cmd_d;
			freq_q      <= freq_d;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (in_acc && emit) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc && emit) begin
			if (res_status == ST_OK) begin
				m_tdata_q <= {freq_d, cmd_d};
			end else begin
				m_tdata_q <= 40'd0;
			end
			m_tuser_q <= res_status;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

endmodule

FILE: hw/rtl/hlxfp_checker.sv
// ----------------------------------------------------------------------------
// hlxfp_checker
// Port-level checks for the frame parser, bound to the top level.
// ----------------------------------------------------------------------------
module hlxfp_checker
	import hlxfp_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [39:0] m_tdata,
	input logic [1:0]  m_tuser
);

	// a stalled result holds its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	// status is one of the defined codes
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tuser == ST_OK || m_tuser == ST_XOR_BAD
			|| m_tuser == ST_OVERSIZE))
		else $error("undefined status code");

	// rejected frames carry zero command and frequency
	a_reject_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser != ST_OK |-> m_tdata == 40'd0)
		else $error("rejected frame with nonzero payload");

	// input is taken whenever the result register is free or draining
	a_ready_rule: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready == (!m_tvalid || m_tready))
		else $error("input ready does not follow result register");

	// a new result follows an accepted byte
	a_result_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(s_tvalid && s_tready))
		else $error("result without an accepted byte");

endmodule

bind header_length_xor_frame_parser hlxfp_checker u_hlxfp_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
